/* design/five_stage_pipeline_hazard_control_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the pipeline hazard controller
// Each macro expands to a concurrent assertion under simulation and to
// nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef FIVE_STAGE_PIPELINE_HAZARD_CONTROL_TOP_MACROS_SVH
`define FIVE_STAGE_PIPELINE_HAZARD_CONTROL_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define FSPC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define FSPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FSPC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define FSPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* design/fspc_pkg.sv */
// ----------------------------------------------------------------------------
// fspc_pkg
// Types, codes and constants shared by the pipeline hazard controller.
// ----------------------------------------------------------------------------
package fspc_pkg;

  localparam int unsigned STAGES            = 5;
  localparam int unsigned TABLE_ENTRIES_DEF = 64;
  localparam int unsigned PC_IDX_SHIFT      = 4;

  localparam logic [3:0] TY_NOP    = 4'd0;
  localparam logic [3:0] TY_RTYPE  = 4'd1;
  localparam logic [3:0] TY_ITYPE  = 4'd2;
  localparam logic [3:0] TY_LOAD   = 4'd3;
  localparam logic [3:0] TY_STORE  = 4'd4;
  localparam logic [3:0] TY_BRANCH = 4'd5;
  localparam logic [3:0] TY_JUMP   = 4'd6;
  localparam logic [3:0] TY_JR     = 4'd8;

  localparam logic [1:0] DA_NONE  = 2'd0;
  localparam logic [1:0] DA_READ  = 2'd1;
  localparam logic [1:0] DA_WRITE = 2'd2;

  localparam logic [7:0] REG_NONE = 8'd255;

  typedef struct packed {
    logic        valid;
    logic [3:0]  kind;
    logic [7:0]  src_a;
    logic [7:0]  src_b;
    logic [7:0]  dest;
    logic [31:0] pc;
    logic [31:0] addr;
  } entry_t;

  localparam entry_t EMPTY_ENTRY = '0;
  localparam entry_t BUBBLE = '{valid: 1'b1, kind: TY_NOP, src_a: REG_NONE,
                                src_b: REG_NONE, dest: REG_NONE, pc: 32'd0, addr: 32'd0};

  typedef struct packed {
    logic        item_valid;
    logic [3:0]  instr_type;
    logic [7:0]  src_a;
    logic [7:0]  src_b;
    logic [7:0]  dest;
    logic [31:0] instr_pc;
    logic [31:0] instr_addr;
  } in_item_t;

  typedef struct packed {
    logic        consumed;
    logic        retire_valid;
    logic [3:0]  retire_type;
    logic [31:0] retire_pc;
    logic        fetch_valid;
    logic [31:0] fetch_pc;
    logic [1:0]  data_access;
    logic [31:0] data_addr;
    logic        stalled;
    logic        flushed;
    logic        drained;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] tag;
    logic        taken;
  } bpt_word_t;

  typedef struct packed {
    logic        rd_en;
    logic [31:0] rd_pc;
    logic        wr_en;
    logic [31:0] look_pc;
    logic        wr_taken;
  } bpt_req_t;

  typedef struct packed {
    logic hit;
    logic taken;
    logic busy;
  } bpt_rsp_t;

endpackage

/* design/fspc_in_if.sv */
// ----------------------------------------------------------------------------
// fspc_in_if
// Instruction request channel: valid/ready handshake with the trace fields.
// ----------------------------------------------------------------------------
interface fspc_in_if;
  logic        valid;
  logic        ready;
  logic        item_valid;
  logic [3:0]  instr_type;
  logic [7:0]  src_a;
  logic [7:0]  src_b;
  logic [7:0]  dest;
  logic [31:0] instr_pc;
  logic [31:0] instr_addr;

  modport source (
    output valid, item_valid, instr_type, src_a, src_b, dest, instr_pc, instr_addr,
    input  ready
  );
  modport sink (
    input  valid, item_valid, instr_type, src_a, src_b, dest, instr_pc, instr_addr,
    output ready
  );
endinterface

/* design/fspc_out_if.sv */
// ----------------------------------------------------------------------------
// fspc_out_if
// Result request channel: valid/ready handshake with the per-tick report.
// ----------------------------------------------------------------------------
interface fspc_out_if;
  logic        valid;
  logic        ready;
  logic        consumed;
  logic        retire_valid;
  logic [3:0]  retire_type;
  logic [31:0] retire_pc;
  logic        fetch_valid;
  logic [31:0] fetch_pc;
  logic [1:0]  data_access;
  logic [31:0] data_addr;
  logic        stalled;
  logic        flushed;
  logic        drained;

  modport source (
    output valid, consumed, retire_valid, retire_type, retire_pc, fetch_valid, fetch_pc,
           data_access, data_addr, stalled, flushed, drained,
    input  ready
  );
  modport sink (
    input  valid, consumed, retire_valid, retire_type, retire_pc, fetch_valid, fetch_pc,
           data_access, data_addr, stalled, flushed, drained,
    output ready
  );
endinterface

/* design/fspc_bpt.sv */
// ----------------------------------------------------------------------------
// fspc_bpt
// Tagged one-bit branch table: index reduction, memory with one registered
// read port, one write port and write bypass, and a clearing sweep after reset.
// ----------------------------------------------------------------------------
`include "five_stage_pipeline_hazard_control_top_macros.svh"

module fspc_bpt import fspc_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  bpt_req_t req,
  output bpt_rsp_t rsp
);

  localparam int unsigned IdxW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned PcBits = 32 - PC_IDX_SHIFT;
  localparam int unsigned SumW  = $clog2(PcBits * TABLE_ENTRIES);

  bpt_word_t       tbl_r [TABLE_ENTRIES];
  bpt_word_t       rd_word_r;
  bpt_word_t       byp_word_r;
  bpt_word_t       cur_word;
  bpt_word_t       wr_word;
  logic            byp_r;
  logic            clr_busy_r;
  logic [IdxW-1:0] clr_idx_r;
  logic [IdxW-1:0] look_idx_r;
  logic [IdxW-1:0] rd_idx;
  logic [IdxW-1:0] wr_idx;
  logic            wr_en;
  logic [SumW-1:0] term [PcBits];
  logic [SumW-1:0] sum;
  logic [SumW-1:0] sub;

  // residue of each index bit's weight
  for (genvar gi = 0; gi < PcBits; gi++) begin : g_weight
    localparam longint unsigned Weight = (64'd1 << gi) % TABLE_ENTRIES;
    assign term[gi] = req.rd_pc[gi + PC_IDX_SHIFT] ? SumW'(Weight) : '0;
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < PcBits; i++) begin
      sum = sum + term[i];
    end
    sub = '0;
    for (int k = 1; k < PcBits; k++) begin
      if (sum >= SumW'(k * TABLE_ENTRIES)) begin
        sub = SumW'(k * TABLE_ENTRIES);
      end
    end
    rd_idx = IdxW'(sum - sub);
  end

  always_comb begin
    wr_en   = clr_busy_r || req.wr_en;
    wr_idx  = clr_busy_r ? clr_idx_r : look_idx_r;
    wr_word = '0;
    if (!clr_busy_r) begin
      wr_word = '{valid: 1'b1, tag: req.look_pc, taken: req.wr_taken};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_r[wr_idx] <= wr_word;
    end
    if (req.rd_en) begin
      rd_word_r  <= tbl_r[rd_idx];
      byp_word_r <= wr_word;
      look_idx_r <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r      <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      if (req.rd_en) begin
        byp_r <= req.wr_en && (look_idx_r == rd_idx);
      end
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + IdxW'(1);
        if (clr_idx_r == IdxW'(TABLE_ENTRIES - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  assign cur_word  = byp_r ? byp_word_r : rd_word_r;
  assign rsp.hit   = cur_word.valid && (cur_word.tag == req.look_pc);
  assign rsp.taken = cur_word.taken;
  assign rsp.busy  = clr_busy_r;

  `FSPC_ASSERT_IMPL(a_idle_while_clearing, clk, rst_n, clr_busy_r, !req.rd_en && !req.wr_en, "table access during clearing sweep")

endmodule

/* design/fspc_pipe.sv */
// ----------------------------------------------------------------------------
// fspc_pipe
// Five-slot pipeline state with load-use stall, jump and branch flush, and
// replay of squashed instructions. One tick per accepted request.
// ----------------------------------------------------------------------------
`include "five_stage_pipeline_hazard_control_top_macros.svh"

module fspc_pipe import fspc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  logic      predict_en,
  input  in_item_t  in_item,
  input  bpt_rsp_t  bpt_rsp,
  output bpt_req_t  bpt_req,
  output out_item_t res
);

  entry_t     slot_r    [STAGES];
  entry_t     slot_nxt  [STAGES];
  entry_t     spare_r   [3];
  entry_t     spare_nxt [3];
  logic [1:0] sc_r;
  logic [1:0] sc_nxt;
  logic       skip_r;
  logic       skip_nxt;
  logic       live_r;
  logic       live_nxt;

  always_comb begin
    entry_t     nx [STAGES];
    entry_t     in_e;
    entry_t     sp0;
    entry_t     nsp1;
    entry_t     nsp2;
    entry_t     s0;
    entry_t     s1;
    logic       taking;
    logic       live;
    logic       drain;
    logic       stall;
    logic       nskip;
    logic [1:0] nsc;
    logic       jump_fl;
    logic       br_cond;
    logic       taken;
    logic       br_fl;
    logic       flush;

    slot_nxt  = slot_r;
    spare_nxt = spare_r;
    sc_nxt    = sc_r;
    skip_nxt  = skip_r;
    live_nxt  = live_r;
    res       = '0;
    bpt_req   = '0;

    s0 = slot_r[0];
    s1 = slot_r[1];
    bpt_req.look_pc = s1.pc;

    taking = !skip_r;
    live   = taking ? in_item.item_valid : live_r;
    in_e   = '{valid: 1'b1, kind: in_item.instr_type, src_a: in_item.src_a,
               src_b: in_item.src_b, dest: in_item.dest, pc: in_item.instr_pc,
               addr: in_item.instr_addr};
    sp0 = spare_r[0];
    if (taking && in_item.item_valid) begin
      sp0 = in_e;
    end
    if (!live) begin
      sp0 = EMPTY_ENTRY;
    end
    drain = !live && !slot_r[STAGES-1].valid;

    // load-use check
    stall = 1'b0;
    if (s0.valid && s1.valid && s1.kind == TY_LOAD) begin
      case (s0.kind)
        TY_RTYPE, TY_STORE, TY_BRANCH: stall = (s1.dest == s0.src_a) || (s1.dest == s0.src_b);
        TY_ITYPE, TY_LOAD, TY_JR:      stall = (s1.dest == s0.src_a);
        default:                       stall = 1'b0;
      endcase
    end

    for (int i = STAGES - 1; i >= 2; i--) begin
      nx[i] = slot_r[i-1];
    end
    nskip = 1'b0;
    nsc   = sc_r;
    if (stall) begin
      nx[1] = BUBBLE;
      nx[0] = s0;
      nskip = 1'b1;
    end else begin
      if (sc_r == 2'd2) begin
        sp0   = spare_r[2];
        nskip = 1'b1;
      end else if (sc_r == 2'd1) begin
        sp0 = spare_r[1];
      end
      if (sc_r != 2'd0) begin
        nsc = sc_r - 2'd1;
      end
      nx[1] = s0;
      nx[0] = sp0;
    end

    jump_fl = nx[2].valid && (nx[2].kind == TY_JUMP || nx[2].kind == TY_JR);
    br_cond = nx[1].valid && nx[2].valid && nx[2].kind == TY_BRANCH;
    taken   = (nx[2].addr == nx[1].pc);
    br_fl   = 1'b0;
    if (br_cond) begin
      if (predict_en) begin
        br_fl = bpt_rsp.hit ? (bpt_rsp.taken != taken) : taken;
      end else begin
        br_fl = taken;
      end
    end
    flush = jump_fl || br_fl;

    // squash the two younger slots and keep them for replay
    nsp1 = spare_r[1];
    nsp2 = spare_r[2];
    if (flush) begin
      nsp1  = nx[0];
      nsp2  = nx[1];
      nx[0] = BUBBLE;
      nx[1] = BUBBLE;
      nsc   = 2'd2;
      nskip = 1'b1;
    end

    if (drain) begin
      res.drained  = 1'b1;
      skip_nxt     = 1'b0;
      spare_nxt[0] = EMPTY_ENTRY;
      live_nxt     = 1'b0;
    end else begin
      slot_nxt     = nx;
      spare_nxt[0] = sp0;
      spare_nxt[1] = nsp1;
      spare_nxt[2] = nsp2;
      sc_nxt       = nsc;
      skip_nxt     = nskip;
      live_nxt     = live;

      bpt_req.rd_en    = step;
      bpt_req.rd_pc    = nx[1].pc;
      bpt_req.wr_en    = step && br_cond && predict_en;
      bpt_req.wr_taken = taken;

      res.consumed = taking && in_item.item_valid;
      if (nx[STAGES-1].valid) begin
        res.retire_valid = 1'b1;
        res.retire_type  = nx[STAGES-1].kind;
        res.retire_pc    = nx[STAGES-1].pc;
      end
      if (nx[0].valid && nx[0].kind != TY_NOP && !nskip) begin
        res.fetch_valid = 1'b1;
        res.fetch_pc    = nx[0].pc;
      end
      if (nx[3].valid && nx[3].kind == TY_LOAD) begin
        res.data_access = DA_READ;
        res.data_addr   = nx[3].addr;
      end else if (nx[3].valid && nx[3].kind == TY_STORE) begin
        res.data_access = DA_WRITE;
        res.data_addr   = nx[3].addr;
      end
      res.stalled = stall;
      res.flushed = flush;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STAGES; i++) begin
        slot_r[i] <= EMPTY_ENTRY;
      end
      for (int i = 0; i < 3; i++) begin
        spare_r[i] <= EMPTY_ENTRY;
      end
      sc_r   <= 2'd0;
      skip_r <= 1'b0;
      live_r <= 1'b0;
    end else if (step) begin
      slot_r  <= slot_nxt;
      spare_r <= spare_nxt;
      sc_r    <= sc_nxt;
      skip_r  <= skip_nxt;
      live_r  <= live_nxt;
    end
  end

  `FSPC_ASSERT_IMPL(a_stall_flush_excl, clk, rst_n, res.stalled, !res.flushed, "stall and flush in the same tick")
  `FSPC_ASSERT_IMPL(a_squash_count_range, clk, rst_n, 1'b1, sc_r != 2'd3, "replay count out of range")
  `FSPC_ASSERT_NEXT(a_flush_holds_fetch, clk, rst_n, step && res.flushed, skip_r && sc_r == 2'd2, "flush did not arm replay")

endmodule

/* design/five_stage_pipeline_hazard_control_top.sv */
// ----------------------------------------------------------------------------
// five_stage_pipeline_hazard_control_top
// Each request on in_ch is one pipeline clock tick of the modelled core and
// carries the next trace instruction, if any; item_valid low marks trace end.
// Each accepted request yields exactly one result on out_ch: consumption,
// retiring entry, fetch and data requests, stall, flush and drained flags.
// Results are registered on acceptance; outside the clearing sweep a request
// can be accepted every cycle while the result register is free or being taken.
// The branch-table index for the slot entering decode/execute is read one
// tick ahead, so the flush decision uses registered table data.
// The result register frees when out_ch.ready is high, so a stalled receiver
// holds in_ch.ready low only while a result is waiting and not being taken.
// After reset the branch table is swept clear, one entry per cycle, over all
// TABLE_ENTRIES entries; in_ch.ready stays low meanwhile, cfg writes still land.
// cfg_we with cfg_wdata sets predict_enable; write it only while idle.
// ----------------------------------------------------------------------------
`include "five_stage_pipeline_hazard_control_top_macros.svh"

module five_stage_pipeline_hazard_control_top import fspc_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  fspc_in_if.sink    in_ch,
  fspc_out_if.source out_ch
);

  logic      predict_en_r;
  logic      out_valid_r;
  out_item_t res_r;
  out_item_t res;
  in_item_t  in_item;
  bpt_req_t  bpt_req;
  bpt_rsp_t  bpt_rsp;
  logic      step;

  assign in_item = '{item_valid: in_ch.item_valid, instr_type: in_ch.instr_type,
                     src_a: in_ch.src_a, src_b: in_ch.src_b, dest: in_ch.dest,
                     instr_pc: in_ch.instr_pc, instr_addr: in_ch.instr_addr};

  assign in_ch.ready = !bpt_rsp.busy && (!out_valid_r || out_ch.ready);
  assign step        = in_ch.valid && in_ch.ready;

  fspc_pipe u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .predict_en (predict_en_r),
    .in_item    (in_item),
    .bpt_rsp    (bpt_rsp),
    .bpt_req    (bpt_req),
    .res        (res)
  );

  fspc_bpt #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_bpt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (bpt_req),
    .rsp   (bpt_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      predict_en_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        predict_en_r <= cfg_wdata;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.consumed     = res_r.consumed;
  assign out_ch.retire_valid = res_r.retire_valid;
  assign out_ch.retire_type  = res_r.retire_type;
  assign out_ch.retire_pc    = res_r.retire_pc;
  assign out_ch.fetch_valid  = res_r.fetch_valid;
  assign out_ch.fetch_pc     = res_r.fetch_pc;
  assign out_ch.data_access  = res_r.data_access;
  assign out_ch.data_addr    = res_r.data_addr;
  assign out_ch.stalled      = res_r.stalled;
  assign out_ch.flushed      = res_r.flushed;
  assign out_ch.drained      = res_r.drained;

  `FSPC_ASSERT_NEXT(a_result_follows_request, clk, rst_n, step, out_valid_r, "accepted request left no result")

endmodule
